/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/dwt_pkg.sv */
`timescale 1ns / 1ps
package dwt_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int OUT_WIDTH      = 18;
    localparam int NUM_TAPS       = 4;
    localparam int TAP_WIDTH      = $clog2(NUM_TAPS);
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 2;
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH      = PROD_WIDTH + TAP_WIDTH;
    localparam int RND_WIDTH      = SUM_WIDTH - COEF_FRAC_BITS;
    localparam int EXT_WIDTH      = ((RND_WIDTH > OUT_WIDTH) ? RND_WIDTH : OUT_WIDTH) + 1;
    localparam int COUNT_WIDTH    = 3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(4);

    typedef enum logic {
        KIND_HAAR = 1'b0,
        KIND_DB4  = 1'b1
    } t_kind;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [SUM_WIDTH-1:0]    t_sum;
    typedef logic signed [OUT_WIDTH-1:0]    t_out;

    // One coefficient pair to compute: filter kind, end flag, taps x[0]..x[3].
    typedef struct packed {
        t_kind                     kind;
        logic                      last;
        t_sample [NUM_TAPS-1:0]    x;
    } t_pair;

    typedef struct packed {
        logic                   odd;
        logic [COUNT_WIDTH-1:0] count;
    } t_front_status;

    // Bitwise integer square root, evaluated at elaboration only.
    function automatic logic [63:0] int_sqrt(input logic [63:0] value);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem  = value;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            probe = 64'd1 << (2 * i);
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
        end
        return root;
    endfunction

    // Round a Q60 magnitude to nearest at COEF_FRAC_BITS, ties up.
    function automatic logic [63:0] q60_round(input logic [63:0] q);
        return (q + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
    endfunction

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] SQRT2_Q30 = int_sqrt(64'd2 << 60);
    localparam logic [63:0] SQRT3_Q30 = int_sqrt(64'd3 << 60);

    localparam t_coef COEF_C  = COEF_WIDTH'(q60_round(SQRT2_Q30 << 29));
    localparam t_coef COEF_H0 = COEF_WIDTH'(q60_round(((Q30_ONE + SQRT3_Q30) * SQRT2_Q30) >> 3));
    localparam t_coef COEF_H1 =
        COEF_WIDTH'(q60_round(((3 * Q30_ONE + SQRT3_Q30) * SQRT2_Q30) >> 3));
    localparam t_coef COEF_H2 =
        COEF_WIDTH'(q60_round(((3 * Q30_ONE - SQRT3_Q30) * SQRT2_Q30) >> 3));
    localparam t_coef COEF_H3 =
        t_coef'(-COEF_WIDTH'(q60_round(((SQRT3_Q30 - Q30_ONE) * SQRT2_Q30) >> 3)));

    localparam t_coef COEF_C_NEG  = -COEF_C;
    localparam t_coef COEF_H0_NEG = -COEF_H0;
    localparam t_coef COEF_H2_NEG = -COEF_H2;

    localparam t_sum ROUND_HALF = t_sum'(SUM_WIDTH'(1) << (COEF_FRAC_BITS - 1));

    localparam logic signed [EXT_WIDTH-1:0] OUT_MAX_EXT =
        {{(EXT_WIDTH - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
    localparam logic signed [EXT_WIDTH-1:0] OUT_MIN_EXT =
        {{(EXT_WIDTH - OUT_WIDTH + 1){1'b1}}, {(OUT_WIDTH - 1){1'b0}}};

    // Low-pass taps: Haar {c, c}, Db4 {h0, h1, h2, h3}.
    function automatic t_coef lo_coef(input t_kind kind, input logic [TAP_WIDTH-1:0] tap);
        t_coef c;
        c = '0;
        unique case (kind)
            KIND_HAAR: begin
                c = (tap <= TAP_WIDTH'(1)) ? COEF_C : '0;
            end
            KIND_DB4: begin
                unique case (tap)
                    TAP_WIDTH'(0): c = COEF_H0;
                    TAP_WIDTH'(1): c = COEF_H1;
                    TAP_WIDTH'(2): c = COEF_H2;
                    default:       c = COEF_H3;
                endcase
            end
        endcase
        return c;
    endfunction

    // High-pass taps: Haar {c, -c}, Db4 {h3, -h2, h1, -h0}.
    function automatic t_coef hi_coef(input t_kind kind, input logic [TAP_WIDTH-1:0] tap);
        t_coef c;
        c = '0;
        unique case (kind)
            KIND_HAAR: begin
                unique case (tap)
                    TAP_WIDTH'(0): c = COEF_C;
                    TAP_WIDTH'(1): c = COEF_C_NEG;
                    default:       c = '0;
                endcase
            end
            KIND_DB4: begin
                unique case (tap)
                    TAP_WIDTH'(0): c = COEF_H3;
                    TAP_WIDTH'(1): c = COEF_H2_NEG;
                    TAP_WIDTH'(2): c = COEF_H1;
                    default:       c = COEF_H0_NEG;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

/* design/dwt_in_if.sv */
`timescale 1ns / 1ps
interface dwt_in_if;
    logic              valid;
    logic              ready;
    dwt_pkg::t_sample  sample;
    logic              last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

/* design/dwt_out_if.sv */
`timescale 1ns / 1ps
interface dwt_out_if;
    logic           valid;
    logic           ready;
    dwt_pkg::t_out  approx;
    dwt_pkg::t_out  detail;
    logic           last_pair;

    modport source (output valid, output approx, output detail, output last_pair, input ready);
    modport sink   (input valid, input approx, input detail, input last_pair, output ready);
endinterface

/* design/dwt_front.sv */
`timescale 1ns / 1ps
module dwt_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dwt_pkg::t_kind          i_kind,
    dwt_in_if.sink                  i_in,
    output logic                    o_issue_valid,
    input  logic                    i_issue_ready,
    output dwt_pkg::t_pair          o_issue,
    output dwt_pkg::t_front_status  o_status
);

    dwt_pkg::t_sample        r_first;
    dwt_pkg::t_sample        r_second;
    dwt_pkg::t_sample        r_win [3];
    dwt_pkg::t_front_status  r_status;

    logic                    r_v;
    logic                    r_has_b;
    dwt_pkg::t_pair          r_pair_a;
    dwt_pkg::t_pair          r_pair_b;

    logic                    take;
    logic                    last;
    logic                    haar_path;
    dwt_pkg::t_sample        x;
    dwt_pkg::t_pair          n_a;
    dwt_pkg::t_pair          n_b;
    logic                    n_has_a;
    logic                    n_has_b;

    assign x          = i_in.sample;
    assign last       = i_in.last_sample;
    // Free the slot when it is empty or its only pair leaves this cycle.
    assign i_in.ready = !r_v || (i_issue_ready && !r_has_b);
    assign take       = i_in.valid && i_in.ready;

    assign o_issue_valid = r_v;
    assign o_issue       = r_pair_a;
    assign o_status      = r_status;

    always_comb begin
        haar_path = (i_kind == dwt_pkg::KIND_HAAR) ||
                    (last && (r_status.count <= dwt_pkg::COUNT_WIDTH'(1)));
        n_has_a   = 1'b0;
        n_has_b   = 1'b0;
        n_a.kind  = dwt_pkg::KIND_HAAR;
        n_a.last  = 1'b0;
        n_a.x     = {dwt_pkg::NUM_TAPS{x}};
        n_b.kind  = dwt_pkg::KIND_DB4;
        n_b.last  = 1'b1;
        n_b.x     = {dwt_pkg::NUM_TAPS{x}};
        priority if (haar_path) begin
            if (r_status.odd) begin
                n_has_a  = 1'b1;
                n_a.last = last;
                n_a.x[0] = r_win[0];
            end else if (last) begin
                // lone sample: pair with itself
                n_has_a  = 1'b1;
                n_a.last = 1'b1;
            end
        end else if (r_status.odd) begin
            n_a.kind = dwt_pkg::KIND_DB4;
            if (r_status.count >= dwt_pkg::COUNT_WIDTH'(3)) begin
                n_has_a  = 1'b1;
                n_a.x[0] = r_win[2];
                n_a.x[1] = r_win[1];
                n_a.x[2] = r_win[0];
                n_has_b  = last;
                n_b.x[0] = r_win[0];
                n_b.x[2] = r_first;
                n_b.x[3] = r_second;
            end
        end else if (last) begin
            // odd length: pad with the last sample, then wrap
            n_a.kind = dwt_pkg::KIND_DB4;
            n_has_a  = 1'b1;
            n_has_b  = 1'b1;
            n_a.x[0] = r_win[1];
            n_a.x[1] = r_win[0];
            n_b.x[2] = r_first;
            n_b.x[3] = r_second;
        end else begin
            n_has_a = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= 1'b0;
            r_has_b   <= 1'b0;
            r_status  <= '0;
            r_first   <= '0;
            r_second  <= '0;
            r_win     <= '{default: '0};
        end else begin
            // Load the pairs a taken item closes; otherwise advance the slot.
            if (take && n_has_a) begin
                r_v      <= 1'b1;
                r_pair_a <= n_a;
                r_pair_b <= n_b;
                r_has_b  <= n_has_b;
            end else if (r_v && i_issue_ready) begin
                if (r_has_b) begin
                    r_pair_a <= r_pair_b;
                    r_has_b  <= 1'b0;
                end else begin
                    r_v <= 1'b0;
                end
            end
            if (take) begin
                if (r_status.count == dwt_pkg::COUNT_WIDTH'(0)) begin
                    r_first <= x;
                end
                if (r_status.count == dwt_pkg::COUNT_WIDTH'(1)) begin
                    r_second <= x;
                end
                r_win[2] <= r_win[1];
                r_win[1] <= r_win[0];
                r_win[0] <= x;
                if (last) begin
                    r_status <= '0;
                end else begin
                    r_status.odd   <= !r_status.odd;
                    r_status.count <= (r_status.count < dwt_pkg::COUNT_MAX) ?
                                      r_status.count + dwt_pkg::COUNT_WIDTH'(1) :
                                      dwt_pkg::COUNT_MAX;
                end
            end
        end
    end

endmodule

/* design/dwt_mac.sv */
`timescale 1ns / 1ps
module dwt_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_issue_valid,
    output logic            o_issue_ready,
    input  dwt_pkg::t_pair  i_issue,
    dwt_out_if.source       o_out
);

    function automatic dwt_pkg::t_out saturate(input dwt_pkg::t_sum s);
        logic signed [dwt_pkg::EXT_WIDTH-1:0] e;
        dwt_pkg::t_out                        res;
        e = dwt_pkg::EXT_WIDTH'($signed(s[dwt_pkg::SUM_WIDTH-1:dwt_pkg::COEF_FRAC_BITS]));
        priority if (e > dwt_pkg::OUT_MAX_EXT) begin
            res = dwt_pkg::OUT_WIDTH'(dwt_pkg::OUT_MAX_EXT);
        end else if (e < dwt_pkg::OUT_MIN_EXT) begin
            res = dwt_pkg::OUT_WIDTH'(dwt_pkg::OUT_MIN_EXT);
        end else begin
            res = dwt_pkg::OUT_WIDTH'(e);
        end
        return res;
    endfunction

    logic            r2_v;
    logic            r3_v;
    logic            r4_v;
    logic            r2_last;
    logic            r3_last;
    logic            r4_last;
    dwt_pkg::t_prod  r2_lo [dwt_pkg::NUM_TAPS];
    dwt_pkg::t_prod  r2_hi [dwt_pkg::NUM_TAPS];
    dwt_pkg::t_sum   r3_lo;
    dwt_pkg::t_sum   r3_hi;
    dwt_pkg::t_out   r4_approx;
    dwt_pkg::t_out   r4_detail;

    dwt_pkg::t_prod  n2_lo [dwt_pkg::NUM_TAPS];
    dwt_pkg::t_prod  n2_hi [dwt_pkg::NUM_TAPS];
    dwt_pkg::t_sum   n3_lo;
    dwt_pkg::t_sum   n3_hi;

    logic            en2;
    logic            en3;
    logic            en4;

    assign en4           = !r4_v || o_out.ready;
    assign en3           = !r3_v || en4;
    assign en2           = !r2_v || en3;
    assign o_issue_ready = en2;

    assign o_out.valid     = r4_v;
    assign o_out.approx    = r4_approx;
    assign o_out.detail    = r4_detail;
    assign o_out.last_pair = r4_last;

    // One multiplier per tap and per filter.
    always_comb begin
        for (int t = 0; t < dwt_pkg::NUM_TAPS; t++) begin
            n2_lo[t] = $signed(i_issue.x[t]) *
                       dwt_pkg::lo_coef(i_issue.kind, dwt_pkg::TAP_WIDTH'(t));
            n2_hi[t] = $signed(i_issue.x[t]) *
                       dwt_pkg::hi_coef(i_issue.kind, dwt_pkg::TAP_WIDTH'(t));
        end
    end

    // Tap sum with the rounding half folded in.
    always_comb begin
        n3_lo = dwt_pkg::ROUND_HALF;
        n3_hi = dwt_pkg::ROUND_HALF;
        for (int t = 0; t < dwt_pkg::NUM_TAPS; t++) begin
            n3_lo = n3_lo + dwt_pkg::SUM_WIDTH'(r2_lo[t]);
            n3_hi = n3_hi + dwt_pkg::SUM_WIDTH'(r2_hi[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en2) begin
                r2_v <= i_issue_valid;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (en4) begin
                r4_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_lo   <= n2_lo;
            r2_hi   <= n2_hi;
            r2_last <= i_issue.last;
        end
        if (en3) begin
            r3_lo   <= n3_lo;
            r3_hi   <= n3_hi;
            r3_last <= r2_last;
        end
        if (en4) begin
            r4_approx <= saturate(r3_lo);
            r4_detail <= saturate(r3_hi);
            r4_last   <= r3_last;
        end
    end

endmodule

/* design/forward_dwt_haar_db4.sv */
// Path: a pair passes the front's issue register, then the product, tap-sum and output
//   registers to o_out; the wrap pair that closes a Db4 signal follows right behind it.
// Throughput: one sample per cycle while o_out is ready; a sample that yields two pairs
//   holds i_in until the first leaves; both pass in turn through the single multiply path.
// Reset: i_rst_n is synchronous, active low; it selects Haar, clears the sample history
//   and empties every stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module forward_dwt_haar_db4 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dwt_in_if.sink      i_in,
    dwt_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    // Filter kind register, read at every accepted item.
    dwt_pkg::t_kind          r_kind;

    // Front to multiply path: one pair per transfer.
    logic                    issue_valid;
    logic                    issue_ready;
    dwt_pkg::t_pair          issue;
    dwt_pkg::t_front_status  status;
    logic                    in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= dwt_pkg::KIND_HAAR;
        end else if (i_cfg_we) begin
            r_kind <= dwt_pkg::t_kind'(i_cfg_wdata);
        end
    end

    // Front: holds the first two samples and a three-deep window, decides on each
    // item which pairs it closes, and parks them in a two-slot issue register.
    dwt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (r_kind),
        .i_in          (i_in),
        .o_issue_valid (issue_valid),
        .i_issue_ready (issue_ready),
        .o_issue       (issue),
        .o_status      (status)
    );

    // Multiply path: products, tap sum with rounding, then scale back and saturate
    // into the output register. Each stage advances whenever the next one frees up.
    dwt_mac u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue_valid (issue_valid),
        .o_issue_ready (issue_ready),
        .i_issue       (issue),
        .o_out         (o_out)
    );

    assign in_take = i_in.valid && i_in.ready;

    // An odd position is only reached after at least one sample of the signal.
    `ASSERT_NEVER(a_odd_needs_count, status.odd && (status.count == '0), "odd position with zero count")
    // The sample count saturates.
    `ASSERT_NEVER(a_count_saturates, status.count > dwt_pkg::COUNT_MAX, "sample count above limit")
    // A last sample restarts the signal bookkeeping.
    `ASSERT_NEXT(a_last_restarts, in_take && i_in.last_sample, (status.count == '0) && !status.odd, "signal state not cleared after last sample")
    // Every Haar item at an odd position closes a pair.
    `ASSERT_NEXT(a_haar_odd_issues, in_take && (r_kind == dwt_pkg::KIND_HAAR) && status.odd, issue_valid, "Haar pair not issued")

endmodule

/* tb/sv/tb_forward_dwt_haar_db4.sv */
`timescale 1ns / 1ps
module tb_forward_dwt_haar_db4;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_TICKS = 10;
    // Covers the issue register, the product, sum and output registers and the wrap pair; leave slack on top.
    localparam int DRAIN_TAIL  = 8;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 56;
    localparam int MAX_SHOWN   = 10;
    localparam longint RUN_LIMIT_NS = 64'd6_000_000;

    // Filter taps at Q1.15, rounded from the exact sqrt(2) / sqrt(3) forms.
    localparam longint TAP_C  = 23170;
    localparam longint TAP_H0 = 15826;
    localparam longint TAP_H1 = 27411;
    localparam longint TAP_H2 = 7345;
    localparam longint TAP_H3 = -4240;
    localparam longint HALF_LSB = 64'sd1 <<< (dwt_pkg::COEF_FRAC_BITS - 1);
    localparam longint OUT_HI = 131071;
    localparam longint OUT_LO = -131072;

    typedef struct packed {
        dwt_pkg::t_out approx;
        dwt_pkg::t_out detail;
        logic          last_pair;
    } t_exp_pair;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_SET_KIND
    } t_row_op;

    // One row of the directed part; typed rows carry their expected pair inline.
    typedef struct {
        t_row_op        op;
        dwt_pkg::t_kind kind;
        int             value;
        logic           last;
        bit             typed;
        int             t_approx;
        int             t_detail;
        logic           t_last;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    dwt_in_if  in_ch ();
    dwt_out_if out_ch ();

    forward_dwt_haar_db4 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow state of the transform, advanced on every accepted item.
    dwt_pkg::t_kind   kind_shadow;
    dwt_pkg::t_sample first_held_q;
    dwt_pkg::t_sample second_held_q;
    dwt_pkg::t_sample win_q [3];
    int               seen_q;
    logic             odd_q;

    t_exp_pair pending_pairs [$];
    int        mismatch_cnt;
    logic      took_item;

    // Typed expectation for the item now on the input, set by the sender.
    bit        typed_armed;
    t_exp_pair typed_pair;

    bit tx_throttle;
    bit rx_throttle;
    int stall_left;
    int sig_left;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // Haar after reset: single-sample signals at the extremes, then a pair
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR, -32768, 1'b1, 1'b1, -46340, 0, 1'b1},
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR,  32767, 1'b1, 1'b1,  46339, 0, 1'b1},
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR,  32767, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR, -32768, 1'b1, 1'b0, 0, 0, 1'b0},
        // odd length: last sample is repeated
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR,    100, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR,    200, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR,    300, 1'b1, 1'b0, 0, 0, 1'b0},
        '{ROW_SET_KIND, dwt_pkg::KIND_DB4,       0, 1'b0, 1'b0, 0, 0, 1'b0},
        // Db4 with a single sample falls back to Haar (x, x)
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,       5, 1'b1, 1'b1, 7, 0, 1'b1},
        // length two: Haar as well
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,    1000, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,   -1000, 1'b1, 1'b0, 0, 0, 1'b0},
        // length four at full swing: one pair plus the wrap pair
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,   32767, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,  -32768, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,   32767, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,  -32768, 1'b1, 1'b0, 0, 0, 1'b0},
        // odd length five: padded pair and wrap pair from one item
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,      10, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,      20, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,      30, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,      40, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,      50, 1'b1, 1'b0, 0, 0, 1'b0},
        // kind switched in the middle of a signal
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,       7, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,       8, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_DB4,       9, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SET_KIND, dwt_pkg::KIND_HAAR,      0, 1'b0, 1'b0, 0, 0, 1'b0},
        '{ROW_SAMPLE,   dwt_pkg::KIND_HAAR,     10, 1'b1, 1'b0, 0, 0, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_forward_dwt_haar_db4: done, errors");
        $finish;
    end

    // Scale a Q1.15 sum back to sample scale, ties toward plus infinity, then clip.
    function automatic dwt_pkg::t_out to_sample_scale(input longint acc);
        longint r;
        r = (acc + HALF_LSB) >>> dwt_pkg::COEF_FRAC_BITS;
        if (r > OUT_HI) r = OUT_HI;
        if (r < OUT_LO) r = OUT_LO;
        return dwt_pkg::t_out'(r);
    endfunction

    function automatic t_exp_pair haar_pair(input dwt_pkg::t_sample a,
                                            input dwt_pkg::t_sample b, input logic last);
        t_exp_pair p;
        p.approx    = to_sample_scale(TAP_C * longint'(a) + TAP_C * longint'(b));
        p.detail    = to_sample_scale(TAP_C * longint'(a) - TAP_C * longint'(b));
        p.last_pair = last;
        return p;
    endfunction

    function automatic t_exp_pair db4_pair(input dwt_pkg::t_sample a,
                                           input dwt_pkg::t_sample b,
                                           input dwt_pkg::t_sample c,
                                           input dwt_pkg::t_sample d, input logic last);
        t_exp_pair p;
        p.approx = to_sample_scale(TAP_H0 * longint'(a) + TAP_H1 * longint'(b)
                                 + TAP_H2 * longint'(c) + TAP_H3 * longint'(d));
        p.detail = to_sample_scale(TAP_H3 * longint'(a) - TAP_H2 * longint'(b)
                                 + TAP_H1 * longint'(c) - TAP_H0 * longint'(d));
        p.last_pair = last;
        return p;
    endfunction

    // Work out the pairs one accepted sample causes and advance the shadow state.
    task automatic transform_sample(input dwt_pkg::t_sample x, input logic last,
                                    output t_exp_pair fresh [2], output int n);
        int               pos;
        dwt_pkg::t_sample w0;
        dwt_pkg::t_sample w1;
        dwt_pkg::t_sample w2;
        pos = seen_q;
        w0  = win_q[0];
        w1  = win_q[1];
        w2  = win_q[2];
        n   = 0;
        if (kind_shadow == dwt_pkg::KIND_HAAR || (last && pos <= 1)) begin
            if (odd_q) begin
                fresh[n++] = haar_pair(w0, x, last);
            end else if (last) begin
                fresh[n++] = haar_pair(x, x, 1'b1);
            end
        end else if (odd_q) begin
            if (pos >= 3) begin
                fresh[n++] = db4_pair(w2, w1, w0, x, 1'b0);
                if (last) begin
                    fresh[n++] = db4_pair(w0, x, first_held_q, second_held_q, 1'b1);
                end
            end
        end else if (last) begin
            // padded tail: repeat the last sample, then wrap to the head
            fresh[n++] = db4_pair(w1, w0, x, x, 1'b0);
            fresh[n++] = db4_pair(x, x, first_held_q, second_held_q, 1'b1);
        end

        if (pos == 0) first_held_q = x;
        if (pos == 1) second_held_q = x;
        win_q[2] = w1;
        win_q[1] = w0;
        win_q[0] = x;
        if (last) begin
            seen_q = 0;
            odd_q  = 1'b0;
        end else begin
            seen_q = (pos < 4) ? pos + 1 : 4;
            odd_q  = ~odd_q;
        end
    endtask

    // Watch both channels at the rising edge: check results, predict on accepted items.
    always @(posedge i_clk) begin
        t_exp_pair fresh [2];
        t_exp_pair want;
        int        n;
        if (!i_rst_n) begin
            kind_shadow   = dwt_pkg::KIND_HAAR;
            first_held_q  = '0;
            second_held_q = '0;
            win_q         = '{default: '0};
            seen_q        = 0;
            odd_q         = 1'b0;
            took_item    <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_pairs.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN) begin
                        $display("unexpected pair: approx %0d detail %0d last %0b",
                                 out_ch.approx, out_ch.detail, out_ch.last_pair);
                    end
                end else begin
                    want = pending_pairs.pop_front();
                    if (out_ch.approx !== want.approx || out_ch.detail !== want.detail ||
                        out_ch.last_pair !== want.last_pair) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_SHOWN) begin
                            $display("pair mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                     want.approx, want.detail, want.last_pair,
                                     out_ch.approx, out_ch.detail, out_ch.last_pair);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                transform_sample(in_ch.sample, in_ch.last_sample, fresh, n);
                if (typed_armed) begin
                    pending_pairs.insert(pending_pairs.size(), typed_pair);
                    typed_armed = 1'b0;
                end else begin
                    for (int k = 0; k < n; k++) begin
                        pending_pairs.insert(pending_pairs.size(), fresh[k]);
                    end
                end
            end
            if (i_cfg_we) kind_shadow = dwt_pkg::t_kind'(i_cfg_wdata);
            took_item <= in_ch.valid && in_ch.ready;
        end
    end

    // Receiver: drop ready for random stretches, mostly short, now and then long.
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (rx_throttle && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_throttle) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Mostly short signals; a few long ones keep the saturated count in play.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 1;
        if (r < 20) return 2;
        if (r < 30) return 3;
        if (r < 85) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic dwt_pkg::t_sample pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0:       return dwt_pkg::t_sample'(32767);
                1:       return dwt_pkg::t_sample'(-32768);
                2:       return dwt_pkg::t_sample'(0);
                default: return dwt_pkg::t_sample'(-1);
            endcase
        end
        if (r < 35) return dwt_pkg::t_sample'(int'($urandom_range(0, 255)) - 128);
        return dwt_pkg::t_sample'($urandom);
    endfunction

    // Present one item from a falling edge, hold it until taken, then idle for a random gap, which may be zero.
    task automatic put_sample(input dwt_pkg::t_sample s, input logic last);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= s;
        in_ch.last_sample <= last;
        do @(negedge i_clk); while (!took_item);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Hold the sender until every expected pair is out and the pipeline is empty.
    task automatic drain_pairs();
        in_ch.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic write_kind(input dwt_pkg::t_kind k);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.last_sample = 1'b0;
        mismatch_cnt      = 0;
        typed_armed       = 1'b0;
        typed_pair        = '0;
        tx_throttle       = 1'b1;
        rx_throttle       = 1'b1;
        sig_left          = 0;

        repeat (RESET_TICKS) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: walk the table; kind changes only once the block is idle.
        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == ROW_SET_KIND) begin
                drain_pairs();
                write_kind(dir_rows[r].kind);
            end else begin
                if (dir_rows[r].typed) begin
                    typed_pair.approx    = dwt_pkg::t_out'(dir_rows[r].t_approx);
                    typed_pair.detail    = dwt_pkg::t_out'(dir_rows[r].t_detail);
                    typed_pair.last_pair = dir_rows[r].t_last;
                    typed_armed          = 1'b1;
                end
                put_sample(dwt_pkg::t_sample'(dir_rows[r].value), dir_rows[r].last);
            end
        end

        // Random part: a continuous stream of signals; phase edges may cut a signal,
        // so the kind also changes mid-signal.
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_pairs();
            write_kind((p % 2 == 0) ? dwt_pkg::KIND_DB4 : dwt_pkg::KIND_HAAR);
            tx_throttle = (p != 2 && p != 6);
            rx_throttle = (p != 5 && p != 6);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (sig_left == 0) sig_left = pick_length();
                put_sample(pick_value(), sig_left == 1);
                sig_left--;
            end
        end

        rx_throttle = 1'b1;
        drain_pairs();

        if (mismatch_cnt == 0 && pending_pairs.size() == 0) begin
            $display("tb_forward_dwt_haar_db4: done, clean");
        end else begin
            $display("tb_forward_dwt_haar_db4: done, errors");
        end
        $finish;
    end

endmodule
